[rtl/qau_pkg.sv]
// Package for the quaternion arithmetic unit: fixed-point format, operation
// codes, item and pipeline carry types. No dependencies.
`timescale 1ns / 1ps

package qau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NSQ_W     = 31;
    localparam int QUEUE_D   = 4;
    localparam int QPTR_W    = $clog2(QUEUE_D);
    localparam int QCNT_W    = $clog2(QUEUE_D + 1);

    typedef enum logic [2:0] {
        KIND_MUL     = 3'd0,
        KIND_MUL_VEC = 3'd1,
        KIND_ADD     = 3'd2,
        KIND_CONJ    = 3'd3,
        KIND_NORM    = 3'd4,
        KIND_NORM_SQ = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_CONJ,
        OP_NORM,
        OP_NSQ,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
    } item_t;

    typedef struct packed {
        op_t              op;
        logic [3:0]       neg;
        logic [3:0][31:0] mag;
        logic [3:0][31:0] r;
        logic [NSQ_W-1:0] nsq;
        status_t          st;
        logic             zero;
    } carry_t;

endpackage

[rtl/qau_front.sv]
// Front end of the quaternion arithmetic unit: accepts input transfers,
// decodes the kind into an operation class and hands items to the queue.
// Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_kind,
    input  logic [31:0]   s_a_w,
    input  logic [31:0]   s_a_x,
    input  logic [31:0]   s_a_y,
    input  logic [31:0]   s_a_z,
    input  logic [31:0]   s_b_w,
    input  logic [31:0]   s_b_x,
    input  logic [31:0]   s_b_y,
    input  logic [31:0]   s_b_z,
    output logic          q_push,
    output qau_pkg::item_t q_item,
    input  logic          q_ready
);
    import qau_pkg::*;

    logic  f_valid_reg, f_valid_next;
    item_t f_item_reg, f_item_next;
    logic  take;

    assign s_ready = !f_valid_reg || q_ready;
    assign take    = s_valid && s_ready;
    assign q_push  = f_valid_reg && q_ready;
    assign q_item  = f_item_reg;

    always_comb begin
        f_item_next.a = {s_a_z, s_a_y, s_a_x, s_a_w};
        f_item_next.b = {s_b_z, s_b_y, s_b_x, s_b_w};
        f_item_next.op = OP_NONE;
        unique case (s_kind)
            KIND_MUL: begin
                f_item_next.op = OP_MUL;
            end
            KIND_MUL_VEC: begin
                f_item_next.op   = OP_MUL;
                f_item_next.b[0] = '0;
            end
            KIND_ADD:     f_item_next.op = OP_ADD;
            KIND_CONJ:    f_item_next.op = OP_CONJ;
            KIND_NORM:    f_item_next.op = OP_NORM;
            KIND_NORM_SQ: f_item_next.op = OP_NSQ;
            default:      f_item_next.op = OP_NONE;
        endcase
    end

    assign f_valid_next = take || (f_valid_reg && !q_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

[rtl/qau_queue.sv]
// Short queue between the front end and the arithmetic back end.
// Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qau_pkg::item_t push_item,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output qau_pkg::item_t pop_item
);
    import qau_pkg::*;

    item_t             mem_reg [QUEUE_D];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = count_reg != QCNT_W'(QUEUE_D);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/qau_back.sv]
// Back end of the quaternion arithmetic unit: products, sums, saturation,
// pipelined square root and per-component division, output register.
// Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  qau_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_r_w,
    output logic [31:0]    m_r_x,
    output logic [31:0]    m_r_y,
    output logic [31:0]    m_r_z,
    output logic [30:0]    m_norm_sq,
    output logic [1:0]     m_status
);
    import qau_pkg::*;

    localparam int NSQ  = 33;
    localparam int NDIV = FRAC_BITS + 1;
    localparam int DW   = FRAC_BITS + 34;
    localparam int QW   = FRAC_BITS + 1;

    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    logic adv;

    // stage 1
    logic               s1_v_reg;
    op_t                s1_op_reg;
    logic [31:0]        s1_a_reg   [4];
    logic signed [63:0] s1_p_reg   [4][4];
    logic [63:0]        s1_sq_reg  [4];
    logic [32:0]        s1_add_reg [4];
    logic [32:0]        s1_neg_reg [4];

    // stage 2
    logic               s2_v_reg;
    op_t                s2_op_reg;
    logic [31:0]        s2_a_reg   [4];
    logic signed [65:0] s2_m_reg   [4];
    logic [64:0]        s2_s_reg;
    logic [32:0]        s2_add_reg [4];
    logic [32:0]        s2_neg_reg [4];

    // square root
    logic               q_v_reg    [NSQ+1];
    carry_t             q_c_reg    [NSQ+1];
    logic [33:0]        q_rem_reg  [NSQ+1];
    logic [32:0]        q_root_reg [NSQ+1];
    logic [65:0]        q_rad_reg  [NSQ+1];

    // division
    logic               d_v_reg    [NDIV];
    carry_t             d_c_reg    [NDIV];
    logic [32:0]        d_s_reg    [NDIV];
    logic [DW-1:0]      d_rem_reg  [NDIV][4];
    logic [QW-1:0]      d_q_reg    [NDIV][4];

    // output
    logic               m_valid_reg;
    logic [31:0]        m_r_reg    [4];
    logic [30:0]        m_nsq_reg;
    status_t            m_st_reg;

    carry_t             c3_next;
    logic [31:0]        r_fin      [4];
    logic [30:0]        nsq_fin;
    status_t            st_fin;

    function automatic logic [31:0] sat33(input logic [32:0] v, output logic sat);
        sat = v[32] != v[31];
        sat33 = sat ? (v[32] ? 32'h8000_0000 : 32'h7fff_ffff) : v[31:0];
    endfunction

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    // products, squares, sums and negations
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg <= q_item.op;
            for (int i = 0; i < 4; i++) begin
                s1_a_reg[i]   <= q_item.a[i];
                s1_sq_reg[i]  <= 64'($signed(q_item.a[i]) * $signed(q_item.a[i]));
                s1_add_reg[i] <= 33'($signed({q_item.a[i][31], q_item.a[i]})
                                 + $signed({q_item.b[i][31], q_item.b[i]}));
                s1_neg_reg[i] <= 33'(-$signed({q_item.a[i][31], q_item.a[i]}));
                for (int j = 0; j < 4; j++) begin
                    s1_p_reg[i][j] <= $signed(q_item.a[i]) * $signed(q_item.b[j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_op_reg <= s1_op_reg;
            s2_a_reg  <= s1_a_reg;
            s2_add_reg <= s1_add_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_m_reg[0] <= 66'(s1_p_reg[0][0]) - 66'(s1_p_reg[1][1])
                         - 66'(s1_p_reg[2][2]) - 66'(s1_p_reg[3][3]);
            s2_m_reg[1] <= 66'(s1_p_reg[0][1]) + 66'(s1_p_reg[1][0])
                         + 66'(s1_p_reg[2][3]) - 66'(s1_p_reg[3][2]);
            s2_m_reg[2] <= 66'(s1_p_reg[0][2]) - 66'(s1_p_reg[1][3])
                         + 66'(s1_p_reg[2][0]) + 66'(s1_p_reg[3][1]);
            s2_m_reg[3] <= 66'(s1_p_reg[0][3]) + 66'(s1_p_reg[1][2])
                         - 66'(s1_p_reg[2][1]) + 66'(s1_p_reg[3][0]);
            s2_s_reg <= 65'(s1_sq_reg[0]) + 65'(s1_sq_reg[1])
                      + 65'(s1_sq_reg[2]) + 65'(s1_sq_reg[3]);
        end
    end

    // saturate and select the direct results
    always_comb begin
        logic               sat, s;
        logic signed [65:0] sh;
        logic [64:0]        ns;
        sat = 1'b0;
        s   = 1'b0;
        sh  = '0;
        c3_next.op   = s2_op_reg;
        c3_next.zero = s2_s_reg == '0;
        c3_next.nsq  = '0;
        for (int i = 0; i < 4; i++) begin
            c3_next.neg[i] = s2_a_reg[i][31];
            c3_next.mag[i] = s2_a_reg[i][31] ? 32'(-s2_a_reg[i]) : s2_a_reg[i];
            c3_next.r[i]   = '0;
        end
        ns = s2_s_reg >> FRAC_BITS;
        case (s2_op_reg)
            OP_MUL: begin
                for (int i = 0; i < 4; i++) begin
                    sh = s2_m_reg[i] >>> FRAC_BITS;
                    if (sh > MAX66) begin
                        c3_next.r[i] = 32'h7fff_ffff;
                        sat = 1'b1;
                    end else if (sh < MIN66) begin
                        c3_next.r[i] = 32'h8000_0000;
                        sat = 1'b1;
                    end else begin
                        c3_next.r[i] = sh[31:0];
                    end
                end
            end
            OP_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    c3_next.r[i] = sat33(s2_add_reg[i], s);
                    sat = sat | s;
                end
            end
            OP_CONJ: begin
                c3_next.r[0] = s2_a_reg[0];
                for (int i = 1; i < 4; i++) begin
                    c3_next.r[i] = sat33(s2_neg_reg[i], s);
                    sat = sat | s;
                end
            end
            OP_NSQ: begin
                if (ns > 65'd2147483647) begin
                    c3_next.nsq = 31'h7fff_ffff;
                    sat = 1'b1;
                end else begin
                    c3_next.nsq = ns[30:0];
                end
            end
            default: begin
            end
        endcase
        c3_next.st = sat ? ST_SAT : ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_c_reg[0]    <= c3_next;
            q_rem_reg[0]  <= '0;
            q_root_reg[0] <= '0;
            q_rad_reg[0]  <= 66'(s2_s_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            q_v_reg[0] <= 1'b0;
        end else if (adv) begin
            s1_v_reg   <= q_valid;
            s2_v_reg   <= s1_v_reg;
            q_v_reg[0] <= s2_v_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        logic [35:0] cur, trial;
        logic        ge;

        always_comb begin
            cur   = {q_rem_reg[k], q_rad_reg[k][65:64]};
            trial = 36'({q_root_reg[k], 2'b01});
            ge    = cur >= trial;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                q_rem_reg[k+1]  <= ge ? 34'(cur - trial) : cur[33:0];
                q_root_reg[k+1] <= {q_root_reg[k][31:0], ge};
                q_rad_reg[k+1]  <= {q_rad_reg[k][63:0], 2'b00};
                q_c_reg[k+1]    <= q_c_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                q_v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                q_v_reg[k+1] <= q_v_reg[k];
            end
        end
    end

    // restoring division, one quotient bit per stage, four lanes
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int SH = FRAC_BITS - j;
        logic          v_in;
        carry_t        c_in;
        logic [32:0]   s_in;
        logic [DW-1:0] rem_in [4];
        logic [QW-1:0] q_in   [4];
        logic [DW-1:0] trial;

        if (j == 0) begin : g_first
            always_comb begin
                v_in = q_v_reg[NSQ];
                c_in = q_c_reg[NSQ];
                s_in = q_root_reg[NSQ];
                for (int i = 0; i < 4; i++) begin
                    rem_in[i] = DW'({q_c_reg[NSQ].mag[i], {FRAC_BITS{1'b0}}});
                    q_in[i]   = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                v_in   = d_v_reg[j-1];
                c_in   = d_c_reg[j-1];
                s_in   = d_s_reg[j-1];
                rem_in = d_rem_reg[j-1];
                q_in   = d_q_reg[j-1];
            end
        end

        assign trial = DW'(s_in) << SH;

        always_ff @(posedge aclk) begin
            if (adv) begin
                d_c_reg[j] <= c_in;
                d_s_reg[j] <= s_in;
                for (int i = 0; i < 4; i++) begin
                    if (rem_in[i] >= trial) begin
                        d_rem_reg[j][i] <= rem_in[i] - trial;
                        d_q_reg[j][i]   <= {q_in[i][QW-2:0], 1'b1};
                    end else begin
                        d_rem_reg[j][i] <= rem_in[i];
                        d_q_reg[j][i]   <= {q_in[i][QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_v_reg[j] <= 1'b0;
            end else if (adv) begin
                d_v_reg[j] <= v_in;
            end
        end
    end

    // final selection
    always_comb begin
        logic [31:0] qv;
        nsq_fin = d_c_reg[NDIV-1].nsq;
        st_fin  = d_c_reg[NDIV-1].st;
        for (int i = 0; i < 4; i++) begin
            qv = 32'(d_q_reg[NDIV-1][i]);
            r_fin[i] = d_c_reg[NDIV-1].r[i];
            if (d_c_reg[NDIV-1].op == OP_NORM) begin
                if (d_c_reg[NDIV-1].zero) begin
                    r_fin[i] = '0;
                end else begin
                    r_fin[i] = d_c_reg[NDIV-1].neg[i] ? 32'(-qv) : qv;
                end
            end
        end
        if (d_c_reg[NDIV-1].op == OP_NORM) begin
            st_fin = d_c_reg[NDIV-1].zero ? ST_ZERO : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_r_reg   <= r_fin;
            m_nsq_reg <= nsq_fin;
            m_st_reg  <= st_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_v_reg[NDIV-1];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_r_w     = m_r_reg[0];
    assign m_r_x     = m_r_reg[1];
    assign m_r_y     = m_r_reg[2];
    assign m_r_z     = m_r_reg[3];
    assign m_norm_sq = m_nsq_reg;
    assign m_status  = m_st_reg;

endmodule

[rtl/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit, signed Q15.16: product, vector product, sum,
// conjugate, normalize and squared norm, with saturation flags.
// Top level; depends on qau_pkg, qau_front, qau_queue, qau_back.
// One item per clock cycle is sustained while m_ready stays high. From input
// transfer to result transfer an item passes the front register, the
// four-entry queue, the product, sum and saturation registers, 33
// square-root stages (one root bit each), FRAC_BITS + 1 division stages (one
// quotient bit each, four lanes) and the output register. All kinds take the
// same path, so results leave in input order. The back pipeline holds while
// the output register is full and not taken; the queue lets the front keep
// accepting until it is full.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_a_w,
    input  logic [31:0] s_a_x,
    input  logic [31:0] s_a_y,
    input  logic [31:0] s_a_z,
    input  logic [31:0] s_b_w,
    input  logic [31:0] s_b_x,
    input  logic [31:0] s_b_y,
    input  logic [31:0] s_b_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_r_w,
    output logic [31:0] m_r_x,
    output logic [31:0] m_r_y,
    output logic [31:0] m_r_z,
    output logic [30:0] m_norm_sq,
    output logic [1:0]  m_status
);
    import qau_pkg::*;

    logic  q_push, q_ready, q_pop, q_valid;
    item_t q_in_item, q_out_item;

    qau_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_a_w   (s_a_w),
        .s_a_x   (s_a_x),
        .s_a_y   (s_a_y),
        .s_a_z   (s_a_z),
        .s_b_w   (s_b_w),
        .s_b_x   (s_b_x),
        .s_b_y   (s_b_y),
        .s_b_z   (s_b_z),
        .q_push  (q_push),
        .q_item  (q_in_item),
        .q_ready (q_ready)
    );

    qau_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_in_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out_item)
    );

    qau_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_r_w     (m_r_w),
        .m_r_x     (m_r_x),
        .m_r_y     (m_r_y),
        .m_r_z     (m_r_z),
        .m_norm_sq (m_norm_sq),
        .m_status  (m_status)
    );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for quaternion_arithmetic_unit: directed and random
// items through valid/ready, results predicted in place. Depends on qau_pkg.
`timescale 1ns / 1ps

module tb_top;
    import qau_pkg::*;

    localparam int LATENCY   = FRAC_BITS + 40;
    localparam int N_RANDOM  = 900;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] a [4];
        logic [31:0] b [4];
    } quat_item_t;

    typedef struct {
        logic [31:0] r [4];
        logic [30:0] nsq;
        logic [1:0]  st;
    } quat_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic [31:0] s_a_w = '0, s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic [31:0] s_b_w = '0, s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_r_w, m_r_x, m_r_y, m_r_z;
    logic [30:0] m_norm_sq;
    logic [1:0] m_status;

    quat_item_t   pending_items [$];
    quat_result_t expected_results [$];
    int  errors = 0;
    int  cycle = 0;
    bit  stim_done = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_off = 0;
    int  accepted = 0;

    quaternion_arithmetic_unit u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Exact 4-term sum in 128 bits, then floor shift.
    function automatic longint prod_comp(longint p0, longint p1, longint p2, longint p3,
                                         ref bit sat);
        logic signed [127:0] acc;
        acc = 128'(p0) + 128'(p1) + 128'(p2) + 128'(p3);
        acc = acc >>> FRAC_BITS;
        if (acc > 128'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (acc < -128'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return longint'(acc);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [127:0] root, bitv;
        root = 0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root[63:0];
    endfunction

    function automatic quat_result_t predict_quat(quat_item_t it);
        quat_result_t res;
        longint a [4], b [4], r [4];
        logic [127:0] sumsq, mag, q, root;
        bit sat;
        sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            a[i] = longint'(signed'(it.a[i]));
            b[i] = longint'(signed'(it.b[i]));
            r[i] = 0;
        end
        res.nsq = '0;
        res.st  = ST_OK;
        case (it.kind)
            KIND_MUL, KIND_MUL_VEC: begin
                if (it.kind == KIND_MUL_VEC) b[0] = 0;
                r[0] = prod_comp(a[0]*b[0], -(a[1]*b[1]), -(a[2]*b[2]), -(a[3]*b[3]), sat);
                r[1] = prod_comp(a[0]*b[1], a[1]*b[0], a[2]*b[3], -(a[3]*b[2]), sat);
                r[2] = prod_comp(a[0]*b[2], -(a[1]*b[3]), a[2]*b[0], a[3]*b[1], sat);
                r[3] = prod_comp(a[0]*b[3], a[1]*b[2], -(a[2]*b[1]), a[3]*b[0], sat);
            end
            KIND_ADD: begin
                for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] + b[i], sat);
            end
            KIND_CONJ: begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++) r[i] = clamp32(-a[i], sat);
            end
            KIND_NORM, KIND_NORM_SQ: begin
                sumsq = 0;
                for (int i = 0; i < 4; i++) sumsq += 128'(a[i] * a[i]);
                if (it.kind == KIND_NORM_SQ) begin
                    q = sumsq >> FRAC_BITS;
                    if (q > 128'd2147483647) begin
                        q = 128'd2147483647;
                        sat = 1'b1;
                    end
                    res.nsq = q[30:0];
                end else if (sumsq == 0) begin
                    res.st = ST_ZERO;
                end else begin
                    root = 128'(int_sqrt(sumsq));
                    for (int i = 0; i < 4; i++) begin
                        mag = 128'(a[i] < 0 ? -a[i] : a[i]);
                        q = (mag << FRAC_BITS) / root;
                        r[i] = a[i] < 0 ? -longint'(q) : longint'(q);
                    end
                end
            end
            default: ;
        endcase
        if (sat && res.st == ST_OK) res.st = ST_SAT;
        for (int i = 0; i < 4; i++) res.r[i] = r[i][31:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_comp(int mode);
        logic [31:0] v;
        v = $urandom;
        case (mode)
            0: return v;
            1: return 32'(signed'(v[19:0]));
            2: return 32'(signed'(v[23:0]));
            default: return 32'(signed'(v[15:0]));
        endcase
    endfunction

    task automatic push_item(logic [2:0] kind, logic [31:0] aw, logic [31:0] ax,
                             logic [31:0] ay, logic [31:0] az, logic [31:0] bw,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        quat_item_t it;
        it.kind = kind;
        it.a[0] = aw; it.a[1] = ax; it.a[2] = ay; it.a[3] = az;
        it.b[0] = bw; it.b[1] = bx; it.b[2] = by; it.b[3] = bz;
        pending_items.push_back(it);
    endtask

    initial begin
        quat_item_t it;
        int mode;
        logic [31:0] mx, mn, one;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        one = 32'h0001_0000;
        push_item(KIND_MUL, one, 0, 0, 0, one, 0, 0, 0);
        push_item(KIND_MUL, mx, mx, mn, mn, mx, mn, mx, mn);
        push_item(KIND_MUL, mn, mn, mn, mn, mn, mn, mn, mn);
        push_item(KIND_MUL, 32'hffff_ffff, 1, 32'hffff_ffff, 1, 1, 1, 32'hffff_ffff, 3);
        push_item(KIND_MUL_VEC, one, one, one, one, mx, one, one, one);
        push_item(KIND_MUL_VEC, mx, mx, mx, mx, mn, mn, mn, mn);
        push_item(KIND_ADD, mx, mn, mx, mn, mx, mn, 32'hffff_ffff, 1);
        push_item(KIND_ADD, 5, 32'hffff_fffb, 0, one, 0, 0, 0, 0);
        push_item(KIND_CONJ, mn, mn, mx, 0, 0, 0, 0, 0);
        push_item(KIND_CONJ, one, 32'hffff_0000, 3, 0, mx, mx, mx, mx);
        push_item(KIND_NORM, 0, 0, 0, 0, one, one, one, one);
        push_item(KIND_NORM, mn, mn, mn, mn, 0, 0, 0, 0);
        push_item(KIND_NORM, mx, mx, mx, mx, 0, 0, 0, 0);
        push_item(KIND_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
        push_item(KIND_NORM, 32'hffff_fffd, 4, 0, 0, 0, 0, 0, 0);
        push_item(KIND_NORM_SQ, mn, mn, mn, mn, 0, 0, 0, 0);
        push_item(KIND_NORM_SQ, one, one, 0, 0, 0, 0, 0, 0);
        push_item(KIND_NORM_SQ, 0, 0, 0, 0, 0, 0, 0, 0);
        push_item(KIND_NORM_SQ, 32'h0000_b504, 32'h0000_b504, 32'h0000_b504, 32'h0000_b504,
                  0, 0, 0, 0);
        push_item(3'd6, one, one, one, one, one, one, one, one);
        push_item(3'd7, mx, mn, mx, mn, mx, mn, mx, mn);
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 3);
            it.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
            for (int i = 0; i < 4; i++) begin
                it.a[i] = rand_comp(mode);
                it.b[i] = rand_comp(mode);
            end
            pending_items.push_back(it);
        end
    end

    // Driver: advance to the next item on each transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                    if (pending_items.size() == 0 && (!s_valid || s_ready))
                        stim_done <= 1'b1;
                end else begin
                    quat_item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= it.kind;
                    s_a_w <= it.a[0]; s_a_x <= it.a[1]; s_a_y <= it.a[2]; s_a_z <= it.a[3];
                    s_b_w <= it.b[0]; s_b_x <= it.b[1]; s_b_y <= it.b[2]; s_b_z <= it.b[3];
                    expected_results.push_back(predict_quat(it));
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // Monitor: check each transfer on the result side, drive ready with stalls.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                quat_result_t want;
                accepted <= accepted + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result r_w=%h", $time, m_r_w);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.r[0] !== m_r_w || want.r[1] !== m_r_x || want.r[2] !== m_r_y ||
                        want.r[3] !== m_r_z || want.nsq !== m_norm_sq ||
                        want.st !== m_status) begin
                        $display("%0t: expected %h %h %h %h nsq=%h st=%0d", $time,
                                 want.r[0], want.r[1], want.r[2], want.r[3], want.nsq,
                                 want.st);
                        $display("%0t: actual   %h %h %h %h nsq=%h st=%0d", $time,
                                 m_r_w, m_r_x, m_r_y, m_r_z, m_norm_sq, m_status);
                        errors <= errors + 1;
                    end
                end
            end
            // Hold off once, long, after a few hundred results have started.
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (accepted == 300 && m_valid && m_ready) begin
                hold_off <= 200;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (cycle > 3000 && cycle < 4500) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle == 8) aresetn <= 1'b1;
        if (cycle >= MAX_CYCLE) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
